// ===== rtl/core/nfcrx_pkg.sv =====
`default_nettype none

package nfcrx_pkg;

	// Result codes.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_GOOD = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 9;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;

	// Frame bytes.
	localparam byte_t PREAMBLE_BYTE = 8'h00;
	localparam byte_t START_BYTE    = 8'hFF;
	localparam byte_t POSTAMBLE     = 8'h00;
	localparam byte_t ACK_LEN       = 8'h00;
	localparam byte_t ACK_LCS       = 8'hFF;

	// Positions within the frame.
	localparam pos_t POS_START = 9'd2;
	localparam pos_t POS_LEN   = 9'd3;
	localparam pos_t POS_LCS   = 9'd4;
	localparam pos_t POS_DATA  = 9'd5;

endpackage

`default_nettype wire

// ===== rtl/core/nfcrx_in_if.sv =====
`default_nettype none

interface nfcrx_in_if;
	import nfcrx_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nfcrx_out_if.sv =====
`default_nettype none

interface nfcrx_out_if;
	import nfcrx_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	byte_t data_value;
	byte_t data_offset;

	modport source (output valid, output kind, output data_value, output data_offset,
		input ready);
	modport sink   (input valid, input kind, input data_value, input data_offset,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nfc_reader_frame_receiver.sv =====
`default_nettype none

// Channel  Dir  Payload                                   Item
// rx       in   rx_byte[7:0]                              one received serial byte
// res      out  kind[1:0], data_value[7:0], data_offset   one frame event or data byte
//
// One item is accepted every cycle when the result side keeps up. An accepted
// byte sits in the input stage and is decoded against the frame state once the
// output register is free or drains, and its result is then registered there.
// The frame state and both valid flags clear on arst_n. When a result waits
// in the output register, the input stage holds and rx.ready falls once it is
// full, so no byte is lost or reordered.

module nfc_reader_frame_receiver (
	input  wire logic   clk,
	input  wire logic   arst_n,
	nfcrx_in_if.sink    rx,
	nfcrx_out_if.source res
);
	import nfcrx_pkg::*;

	// Input stage.
	logic  valid_s1;
	byte_t byte_s1;

	// Frame state.
	pos_t  pos_q;
	byte_t len_q;
	byte_t lcs_q;
	byte_t plen_q;
	byte_t sum_q;
	byte_t dcs_q;

	// Output register.
	logic  out_valid_q;
	kind_t kind_q;
	byte_t value_q;
	byte_t offset_q;

	logic advance;

	// The input stage moves on when the output register is free or drains now.
	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Decode of one byte against the current frame state.
	pos_t  pos_d;
	byte_t len_d, lcs_d, plen_d, sum_d, dcs_d;
	logic  emit;
	kind_t kind_d;
	byte_t value_d, offset_d;
	byte_t plen_eff, sum_eff;
	pos_t  off;
	pos_t  plen_ext;
	pos_t  pos_inc;
	byte_t sync_expect;
	byte_t len_sum;

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		lcs_d    = lcs_q;
		plen_d   = plen_q;
		sum_d    = sum_q;
		dcs_d    = dcs_q;
		emit     = 1'b0;
		kind_d   = KIND_DATA;
		value_d  = '0;
		offset_d = '0;

		pos_inc     = pos_q + pos_t'(1);
		sync_expect = (pos_q == POS_START) ? START_BYTE : PREAMBLE_BYTE;
		len_sum     = len_q + lcs_q;

		// On the first data place the length is taken straight from LEN.
		plen_eff = (pos_q == POS_DATA) ? len_q : plen_q;
		sum_eff  = (pos_q == POS_DATA) ? byte_t'(0) : sum_q;
		off      = pos_q - POS_DATA;
		plen_ext = pos_t'(plen_eff);

		if (pos_q < POS_LEN) begin
			pos_d = (byte_s1 == sync_expect) ? pos_inc : pos_t'(0);
		end else if (pos_q == POS_LEN) begin
			len_d = byte_s1;
			pos_d = POS_LCS;
		end else if (pos_q == POS_LCS) begin
			lcs_d = byte_s1;
			pos_d = POS_DATA;
		end else if (pos_q == POS_DATA && len_q == ACK_LEN && lcs_q == ACK_LCS
				&& byte_s1 == POSTAMBLE) begin
			// ACK frame: 00 FF 00 after the start code.
			pos_d  = '0;
			emit   = 1'b1;
			kind_d = KIND_ACK;
		end else if (pos_q == POS_DATA && len_sum != '0) begin
			// Length check failed: drop the frame quietly.
			pos_d = '0;
		end else begin
			plen_d = plen_eff;
			sum_d  = sum_eff;
			if (off < plen_ext) begin
				sum_d    = sum_eff + byte_s1;
				pos_d    = pos_inc;
				emit     = 1'b1;
				kind_d   = KIND_DATA;
				value_d  = byte_s1;
				offset_d = off[BYTE_W-1:0];
			end else if (off == plen_ext) begin
				dcs_d = byte_s1;
				pos_d = pos_inc;
			end else begin
				// Postamble place, or anything past it, closes the frame.
				pos_d   = '0;
				emit    = 1'b1;
				kind_d  = ((byte_t'(sum_eff + dcs_q) == '0) && byte_s1 == POSTAMBLE)
					? KIND_GOOD : KIND_BAD;
				value_d = plen_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			lcs_q  <= '0;
			plen_q <= '0;
			sum_q  <= '0;
			dcs_q  <= '0;
		end else if (advance) begin
			pos_q  <= pos_d;
			len_q  <= len_d;
			lcs_q  <= lcs_d;
			plen_q <= plen_d;
			sum_q  <= sum_d;
			dcs_q  <= dcs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q   <= kind_d;
			value_q  <= value_d;
			offset_q <= offset_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = kind_q;
	assign res.data_value  = value_q;
	assign res.data_offset = offset_q;

endmodule

`default_nettype wire

// ===== rtl/core/nfcrx_checker.sv =====
`default_nettype none

module nfcrx_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire nfcrx_pkg::kind_t kind,
	input wire nfcrx_pkg::byte_t data_value,
	input wire nfcrx_pkg::byte_t data_offset
);
	import nfcrx_pkg::*;

	// A result waiting for the sink stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its fields.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(kind) && $stable(data_value)
			&& $stable(data_offset))
		else $error("result changed while stalled");

	// An ACK carries no length and no offset.
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_ACK |-> data_value == '0 && data_offset == '0)
		else $error("ACK with nonzero fields");

	// Frame end reports carry no offset.
	a_end_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_GOOD || kind == KIND_BAD) |-> data_offset == '0)
		else $error("frame end with nonzero offset");

endmodule

bind nfc_reader_frame_receiver nfcrx_checker u_nfcrx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.kind        (res.kind),
	.data_value  (res.data_value),
	.data_offset (res.data_offset)
);

`default_nettype wire
